// ===== src/lksd_pkg.sv =====
// Shared types, constants and the generator step for the keyed byte substitution decryptor.
// No dependencies; every other file in src/ refers to this package by scoped names.
`default_nettype none

package lksd_pkg;

	// Generator constants
	localparam logic [15:0] SEED_RESET = 16'd728;
	localparam logic [15:0] LCG_MUL    = 16'd25173;
	localparam logic [15:0] LCG_ADD    = 16'd13849;

	// Table geometry
	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned FILL_W      = 9;

	// Default depth of the input queue
	localparam int unsigned QUEUE_DEPTH = 4;

	// One input word
	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       last_in;
	} in_t;

	// One result word
	typedef struct packed {
		logic [7:0] plain_byte;
		logic       last_out;
	} out_t;

	// Builder to lookup side: table write port and build status
	typedef struct packed {
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [7:0] wr_data;
		logic       table_ready;
	} build_t;

	// x' = (25173 * x + 13849) mod 2^16
	function automatic logic [15:0] lcg_next(input logic [15:0] x);
		logic [31:0] prod;
		prod = {16'd0, x} * {16'd0, LCG_MUL};
		return prod[15:0] + LCG_ADD;
	endfunction

	// floor(x * 256 / 65535) clipped to 255 equals the high byte of x:
	// with q = x[15:8], 256x - q*65535 = 256*x[7:0] + q, which reaches
	// 65535 only for x = 65535, where the clip gives 255 = q anyway.
	function automatic logic [7:0] lcg_scale(input logic [15:0] x);
		return x[15:8];
	endfunction

endpackage

`default_nettype wire

// ===== src/lksd_front.sv =====
// Front end: accepts cipher words and holds them in a short queue for the lookup side.
// Depends on lksd_pkg for the input word type.
`default_nettype none

module lksd_front #(
	parameter int unsigned Depth = lksd_pkg::QUEUE_DEPTH  // at least 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cipher_valid,
	output logic              cipher_stall,
	input  wire lksd_pkg::in_t cipher,
	output lksd_pkg::in_t     head,
	output logic              head_valid,
	input  wire logic         pop
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	lksd_pkg::in_t   slot_q [Depth];
	logic            push;

	// Queue status
	assign cipher_stall = (count_q == CntW'(Depth));
	assign push         = cipher_valid && !cipher_stall;
	assign head_valid   = (count_q != '0);
	assign head         = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cipher;
		end
	end

	// The lookup side only drains a nonempty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	// Fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count overflow");

endmodule

`default_nettype wire

// ===== src/lksd_build.sv =====
// Table builder: steps the generator from the seed and fills the inverse table once per seed.
// Depends on lksd_pkg for the generator step, scaling and the build_t status word.
`default_nettype none

module lksd_build (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_we,
	input  wire logic [15:0] seed,
	output lksd_pkg::build_t tbl
);

	localparam int unsigned FillW = lksd_pkg::FILL_W;

	logic [15:0]                        gen_q;
	logic [FillW-1:0]                   fill_q;
	logic [lksd_pkg::TABLE_DEPTH-1:0]   used_q;
	logic [15:0]                        gen_next;
	logic [7:0]                         r;
	logic                               building;
	logic                               place;

	// One generator step per cycle while the table is incomplete
	assign building = !fill_q[FillW-1];
	assign gen_next = lksd_pkg::lcg_next(gen_q);
	assign r        = lksd_pkg::lcg_scale(gen_next);
	assign place    = building && !used_q[r];

	assign tbl.wr_en       = place && !seed_we;
	assign tbl.wr_addr     = r;
	assign tbl.wr_data     = fill_q[7:0];
	assign tbl.table_ready = !building;

	// Generator, fill position and used marks; a seed write restarts the build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q  <= lksd_pkg::SEED_RESET;
			fill_q <= '0;
			used_q <= '0;
		end else if (seed_we) begin
			gen_q  <= seed;
			fill_q <= '0;
			used_q <= '0;
		end else if (building) begin
			gen_q <= gen_next;
			if (place) begin
				used_q[r] <= 1'b1;
				fill_q    <= fill_q + FillW'(1);
			end
		end
	end

	// Once complete, the fill position sits exactly at the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[FillW-1] |-> (fill_q[FillW-2:0] == '0))
		else $error("fill position past table size");

	// Each placed entry is marked used on the next cycle
	a_mark_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		tbl.wr_en |=> used_q[$past(r)])
		else $error("placed entry not marked used");

endmodule

`default_nettype wire

// ===== src/lksd_back.sv =====
// Back end: holds the inverse table, looks up queued words and registers the plain output.
// Depends on lksd_pkg for word types and the builder's build_t write port.
`default_nettype none

module lksd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lksd_pkg::build_t  tbl,
	input  wire lksd_pkg::in_t     head,
	input  wire logic              head_valid,
	output logic                   pop,
	output logic                   plain_valid,
	input  wire logic              plain_stall,
	output lksd_pkg::out_t         plain
);

	logic [7:0] table_mem [lksd_pkg::TABLE_DEPTH];
	logic [7:0] rdata_s1;
	logic       last_s1;
	logic       valid_s1;
	logic       adv_out;
	logic       load_s1;

	// Flow control: output register frees when empty or taken
	assign adv_out = !plain_valid || !plain_stall;
	assign load_s1 = !valid_s1 || adv_out;
	assign pop     = tbl.table_ready && head_valid && load_s1;

	// Inverse table: builder writes, lookup reads with registered data
	always_ff @(posedge clk) begin
		if (tbl.wr_en) begin
			table_mem[tbl.wr_addr] <= tbl.wr_data;
		end
		if (pop) begin
			rdata_s1 <= table_mem[head.cipher_byte];
			last_s1  <= head.last_in;
		end
	end

	// Valid bits of the read stage and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			plain_valid <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= pop;
			end
			if (adv_out) begin
				plain_valid <= valid_s1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			plain.plain_byte <= rdata_s1;
			plain.last_out   <= last_s1;
		end
	end

	// Lookups never overlap a table build
	a_pop_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (tbl.table_ready && !tbl.wr_en))
		else $error("lookup during table build");

endmodule

`default_nettype wire

// ===== src/lcg_keyed_byte_substitution_decrypt.sv =====
// Keyed byte substitution decryptor: each cipher word returns one plain word from an
// inverse table built from a 16-bit LCG. After reset or a seed write, the builder runs one
// generator step per cycle until all 256 table entries are placed; how long that takes
// depends on the seed. Cipher words may be sent during the build; they wait in the input
// queue and the lookup side holds them until the table is complete. Once built, one word is
// taken and one delivered per cycle while plain_stall is low, limited by the single read
// port of the table memory; an accepted word passes through the input queue, the table read
// stage and the output register. The seed port is always ready and takes effect at once,
// restarting the build. Depends on lksd_pkg, lksd_front, lksd_build and lksd_back.
`default_nettype none

module lcg_keyed_byte_substitution_decrypt #(
	parameter int unsigned QueueDepth = lksd_pkg::QUEUE_DEPTH  // at least 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// cipher words
	input  wire logic           cipher_valid,
	output logic                cipher_stall,
	input  wire lksd_pkg::in_t  cipher,
	// plain words
	output logic                plain_valid,
	input  wire logic           plain_stall,
	output lksd_pkg::out_t      plain,
	// seed register write
	input  wire logic           seed_valid,
	output logic                seed_ready,
	input  wire logic [15:0]    seed
);

	lksd_pkg::in_t    head;
	logic             head_valid;
	logic             pop;
	lksd_pkg::build_t tbl;

	assign seed_ready = 1'b1;

	lksd_front #(
		.Depth(QueueDepth)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cipher_valid (cipher_valid),
		.cipher_stall (cipher_stall),
		.cipher       (cipher),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop)
	);

	lksd_build u_build (
		.clk     (clk),
		.arst_n  (arst_n),
		.seed_we (seed_valid && seed_ready),
		.seed    (seed),
		.tbl     (tbl)
	);

	lksd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tbl         (tbl),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.plain_valid (plain_valid),
		.plain_stall (plain_stall),
		.plain       (plain)
	);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for lcg_keyed_byte_substitution_decrypt: directed words, then random
// resources under several seeds, each result checked against a local inverse-table predictor.
// Depends on lksd_pkg and the RTL in src/.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned GEN_MUL     = 25173;
	localparam int unsigned GEN_INC     = 13849;
	localparam int unsigned SCALE_DEN   = 65535;
	localparam int unsigned TBL_SIZE    = 256;
	localparam int unsigned PHASE_WORDS = 203;
	localparam int unsigned NUM_PHASES  = 7;
	localparam int unsigned REPORT_MAX  = 10;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int N_DIRECTED = 16;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cipher_valid = 1'b0;
	logic           cipher_stall;
	lksd_pkg::in_t  cipher = '0;
	logic           plain_valid;
	logic           plain_stall = 1'b0;
	lksd_pkg::out_t plain;
	logic           seed_valid = 1'b0;
	logic           seed_ready;
	logic [15:0]    seed = '0;

	lcg_keyed_byte_substitution_decrypt u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cipher_valid (cipher_valid),
		.cipher_stall (cipher_stall),
		.cipher       (cipher),
		.plain_valid  (plain_valid),
		.plain_stall  (plain_stall),
		.plain        (plain),
		.seed_valid   (seed_valid),
		.seed_ready   (seed_ready),
		.seed         (seed)
	);

	// Clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Predictor state: inverse table, seed, and whether the table is current
	logic [7:0]     inv_tbl [TBL_SIZE];
	logic [15:0]    key_seed = lksd_pkg::SEED_RESET;
	bit             tbl_valid = 1'b0;
	lksd_pkg::out_t expected_plain [$];

	int unsigned words_sent = 0;
	int unsigned words_checked = 0;
	int unsigned seed_writes = 0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;  // no idling on either side while set

	// Directed words: byte extremes, walking ones, both flag values. Plain values
	// hinge on the full table build, so every row goes through the predictor.
	lksd_pkg::in_t directed_words [N_DIRECTED] = '{
		'{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h00, 1'b1}, '{8'hFF, 1'b1},
		'{8'h01, 1'b0}, '{8'h02, 1'b0}, '{8'h04, 1'b0}, '{8'h08, 1'b0},
		'{8'h10, 1'b0}, '{8'h20, 1'b0}, '{8'h40, 1'b0}, '{8'h80, 1'b1},
		'{8'h7F, 1'b0}, '{8'hFE, 1'b0}, '{8'h55, 1'b0}, '{8'hAA, 1'b1}
	};

	// Walk the generator from the seed; each fresh scaled value r gets the fill index
	function automatic void rebuild_inverse();
		bit          taken [TBL_SIZE];
		int unsigned x;
		int unsigned r;
		int unsigned pos;
		int unsigned steps;
		taken = '{default: 1'b0};
		x = key_seed;
		pos = 0;
		steps = 0;
		while (pos < TBL_SIZE && steps < 65536) begin
			x = (x * GEN_MUL + GEN_INC) & 32'hFFFF;
			r = (x * 256) / SCALE_DEN;
			if (r > TBL_SIZE - 1) r = TBL_SIZE - 1;
			if (!taken[r]) begin
				taken[r] = 1'b1;
				inv_tbl[r] = pos[7:0];
				pos++;
			end
			steps++;
		end
		tbl_valid = 1'b1;
	endfunction

	function automatic lksd_pkg::out_t decrypt_word(input lksd_pkg::in_t w);
		lksd_pkg::out_t o;
		if (!tbl_valid) rebuild_inverse();
		o.plain_byte = inv_tbl[w.cipher_byte];
		o.last_out   = w.last_in;
		return o;
	endfunction

	function automatic int unsigned pause_len();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_MAX) $display("mismatch @%0t: %s", $realtime, msg);
	endfunction

	// Send one cipher word after a random gap; record its expected plain word
	task automatic send_word(input lksd_pkg::in_t w);
		int unsigned n;
		n = pause_len();
		if (n > 0) begin
			cipher_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		cipher_valid <= 1'b1;
		cipher <= w;
		@(posedge clk);
		while (cipher_stall) @(posedge clk);
		expected_plain.push_back(decrypt_word(w));
		words_sent++;
	endtask

	// Mostly well-formed resources ending in last; some noise with random flags
	task automatic send_random(input int unsigned count);
		int unsigned done;
		int unsigned len;
		bit          noise;
		lksd_pkg::in_t w;
		done = 0;
		while (done < count) begin
			calm = ($urandom_range(0, 5) == 0);
			noise = ($urandom_range(0, 99) < 15);
			len = noise ? $urandom_range(1, 8) : $urandom_range(1, 32);
			for (int unsigned i = 0; i < len; i++) begin
				w.cipher_byte = 8'($urandom);
				w.last_in = noise ? 1'($urandom) : (i == len - 1);
				send_word(w);
			end
			done += len;
		end
		calm = 1'b0;
	endtask

	// Seed writes, back to back when more than one
	task automatic load_seeds(input logic [15:0] vals [$]);
		foreach (vals[i]) begin
			seed_valid <= 1'b1;
			seed <= vals[i];
			@(posedge clk);
			while (!seed_ready) @(posedge clk);
			key_seed = vals[i];
			tbl_valid = 1'b0;
			seed_writes++;
		end
		seed_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_plain.size() != 0) @(posedge clk);
	endtask

	// Result side: random stall per word, then check against the oldest expectation
	initial begin : plain_side
		int unsigned    n;
		lksd_pkg::out_t want;
		@(posedge arst_n);
		forever begin
			n = pause_len();
			if (n > 0) begin
				plain_stall <= 1'b1;
				repeat (n) @(posedge clk);
				plain_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(plain_valid && !plain_stall)) @(posedge clk);
			if (expected_plain.size() == 0) begin
				note_fault($sformatf("plain word %0h/%0b with none expected",
					plain.plain_byte, plain.last_out));
			end else begin
				want = expected_plain.pop_front();
				if (plain.plain_byte !== want.plain_byte)
					note_fault($sformatf("plain_byte exp %0h got %0h",
						want.plain_byte, plain.plain_byte));
				if (plain.last_out !== want.last_out)
					note_fault($sformatf("last_out exp %0b got %0b",
						want.last_out, plain.last_out));
			end
			words_checked++;
		end
	end

	// Watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d words outstanding",
					cycle_count, expected_plain.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin : stimulus
		logic [15:0] seeds [$];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset seed; the first words arrive while the table is still being built
		foreach (directed_words[i]) send_word(directed_words[i]);
		send_random(PHASE_WORDS);
		cipher_valid <= 1'b0;

		for (int unsigned ph = 1; ph < NUM_PHASES; ph++) begin
			wait_drained();
			seeds = {};
			case (ph)
				1: seeds.push_back(16'h0000);
				2: seeds.push_back(16'hFFFF);
				3: begin
					// restart the build with a second write, back to the reset seed
					seeds.push_back(16'($urandom));
					seeds.push_back(lksd_pkg::SEED_RESET);
				end
				default: seeds.push_back(16'($urandom_range(0, 65535)));
			endcase
			load_seeds(seeds);
			send_word('{8'h00, 1'b0});
			send_word('{8'hFF, 1'b1});
			send_random(PHASE_WORDS);
			cipher_valid <= 1'b0;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_plain.size() != 0)
			note_fault($sformatf("%0d plain words never arrived", expected_plain.size()));

		$display("run: %0d cipher words, %0d plain words checked, %0d seed writes",
			words_sent, words_checked, seed_writes);
		$display("seeds: reset value, 0, 65535, back-to-back pair, random; %0d mismatches",
			fault_count);
		if (fault_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/lksd_pkg.sv
src/lksd_front.sv
src/lksd_build.sv
src/lksd_back.sv
src/lcg_keyed_byte_substitution_decrypt.sv
sim/tb.sv
